// ----- rtl/sfs_pkg.sv -----
// Shared constants and code types for the sorting/filtering stack.
package sfs_pkg;

  localparam int DEPTH_DEF      = 32;
  localparam int DATA_WIDTH_DEF = 32;

  localparam int OP_W     = 3;
  localparam int VAL_W    = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 6;
  localparam int EXT_W    = 64;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH        = 3'd0,
    OP_POP         = 3'd1,
    OP_CREATE      = 3'd2,
    OP_CLEAR       = 3'd3,
    OP_REMOVE_EVEN = 3'd4,
    OP_SORT        = 3'd5,
    OP_DUMP        = 3'd6
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_t;

endpackage

// ----- rtl/sfs_mem.sv -----
// Element store: one write port, one read port with registered read data.
module sfs_mem #(
  parameter int DEPTH      = sfs_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = sfs_pkg::DATA_WIDTH_DEF,
  parameter int AW         = $clog2(DEPTH)
) (
  input  logic                  clk,
  input  logic                  we,
  input  logic [AW-1:0]         waddr,
  input  logic [DATA_WIDTH-1:0] wdata,
  input  logic                  re,
  input  logic [AW-1:0]         raddr,
  output logic [DATA_WIDTH-1:0] rdata
);
  import sfs_pkg::*;

  logic [DATA_WIDTH-1:0] mem [DEPTH];
  logic [DATA_WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read data holds while no read is issued
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/sfs_cmp.sv -----
// Shared signed comparator used by the bubble sort passes.
module sfs_cmp #(
  parameter int DATA_WIDTH = sfs_pkg::DATA_WIDTH_DEF
) (
  input  logic [DATA_WIDTH-1:0] a,
  input  logic [DATA_WIDTH-1:0] b,
  output logic                  a_lt_b
);
  import sfs_pkg::*;

  assign a_lt_b = $signed(a) < $signed(b);

endmodule

// ----- rtl/sorting_filtering_stack.sv -----
// Top level: bounded stack with remove-even filter, bubble sort and dump.
//
//  channel | ports                                          | direction
//  --------+------------------------------------------------+----------
//  in      | in_valid, in_ready, in_operation, in_push_value | into block
//  out     | out_valid, out_ready, out_status,               | out of block
//          | out_element_value, out_holds_element,          |
//          | out_element_count, out_last                    |
//
// Steps (sequencer busy, accept step included): push, pop, create, clear
//   go through accept/update, top read issue and top read return through
//   the store's registered read port. Remove-even reads and checks each
//   element in turn, then reports the top. Sort runs passes over L elements
//   (one compare per cycle on the shared comparator), for L = n down to 2,
//   then reports the top. Dump reads and emits each element from the top
//   down. The top read is skipped whenever the stack ends up empty.
// Reset (rst_n low, synchronous) empties the stack; store contents are not
//   cleared, only entries below the fill count are ever read.
// in_ready is high only while the sequencer is idle. A result waiting in the
//   output register does not block the next accept; the sequencer stalls
//   only when it has a new result and the output register is still full.
module sorting_filtering_stack #(
  parameter int DEPTH      = sfs_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = sfs_pkg::DATA_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // input transactions
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [sfs_pkg::OP_W-1:0]           in_operation,
  input  logic signed [sfs_pkg::VAL_W-1:0]   in_push_value,
  // result transactions
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [sfs_pkg::STATUS_W-1:0]       out_status,
  output logic signed [sfs_pkg::VAL_W-1:0]   out_element_value,
  output logic                               out_holds_element,
  output logic [sfs_pkg::COUNT_W-1:0]        out_element_count,
  output logic                               out_last
);
  import sfs_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_TOP_RD,    // issue read of the top entry
    S_TOP_EM,    // single result with top value
    S_RE_RD,     // remove-even: read next element
    S_RE_CHK,    // remove-even: keep odd element
    S_SRT_LD,    // sort pass: read entry 0
    S_SRT_HOLD,  // sort pass: capture entry 0, read entry 1
    S_SRT_CMP,   // sort pass: one compare/exchange per cycle
    S_SRT_END,   // sort pass: park the carried value in the last slot below the pass limit
    S_DMP_RD,    // dump: read next element from the top
    S_DMP_EM     // dump: emit it
  } state_t;

  state_t                state_r, state_nxt;
  logic [CW-1:0]         cnt_r, cnt_nxt;     // fill count
  logic [CW-1:0]         idx_r, idx_nxt;     // walk index
  logic [CW-1:0]         lim_r, lim_nxt;     // sort pass limit
  logic [CW-1:0]         wr_r, wr_nxt;       // remove-even write index
  logic [DATA_WIDTH-1:0] hold_r, hold_nxt;   // value carried through a pass
  status_t               st_r, st_nxt;

  logic                  out_valid_r, out_valid_nxt;
  status_t               out_status_r, out_status_nxt;
  logic [DATA_WIDTH-1:0] out_val_r, out_val_nxt;
  logic                  out_holds_r, out_holds_nxt;
  logic [CW-1:0]         out_cnt_r, out_cnt_nxt;
  logic                  out_last_r, out_last_nxt;

  // store ports
  logic                  mem_we, mem_re;
  logic [AW-1:0]         mem_waddr, mem_raddr;
  logic [DATA_WIDTH-1:0] mem_wdata, mem_rdata;

  logic                  lt;
  logic                  out_free;
  logic [CW-1:0]         idx_p1, idx_p2, cnt_m1, lim_m1;
  logic signed [EXT_W-1:0] push_ext;
  logic [DATA_WIDTH-1:0] push_st;
  logic signed [EXT_W-1:0] out_ext;

  sfs_mem #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH),
    .AW         (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // carried value against the freshly read neighbour
  sfs_cmp #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_cmp (
    .a      (hold_r),
    .b      (mem_rdata),
    .a_lt_b (lt)
  );

  assign in_ready = (state_r == S_IDLE);
  assign out_free = !out_valid_r || out_ready;

  // push value: sign-extend from 32 bits, then cut to the stored width
  assign push_ext = EXT_W'(in_push_value);
  assign push_st  = push_ext[DATA_WIDTH-1:0];

  assign idx_p1 = idx_r + CW'(1);
  assign idx_p2 = idx_r + CW'(2);
  assign cnt_m1 = cnt_r - CW'(1);
  assign lim_m1 = lim_r - CW'(1);

  function automatic logic [AW-1:0] idx_m1_addr(input logic [CW-1:0] i);
    logic [CW-1:0] d;
    d = i - CW'(1);
    return d[AW-1:0];
  endfunction

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    idx_nxt        = idx_r;
    lim_nxt        = lim_r;
    wr_nxt         = wr_r;
    hold_nxt       = hold_r;
    st_nxt         = st_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_val_nxt    = out_val_r;
    out_holds_nxt  = out_holds_r;
    out_cnt_nxt    = out_cnt_r;
    out_last_nxt   = out_last_r;
    mem_we         = 1'b0;
    mem_waddr      = '0;
    mem_wdata      = hold_r;
    mem_re         = 1'b0;
    mem_raddr      = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          st_nxt    = ST_OK;
          state_nxt = S_TOP_RD;
          case (op_t'(in_operation))
            OP_PUSH: begin
              if (cnt_r == CW'(DEPTH)) begin
                st_nxt = ST_OVERFLOW;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = cnt_r[AW-1:0];
                mem_wdata = push_st;
                cnt_nxt   = cnt_r + CW'(1);
              end
            end
            OP_POP: begin
              if (cnt_r == '0) begin
                st_nxt = ST_UNDERFLOW;
              end else begin
                cnt_nxt = cnt_m1;
              end
            end
            OP_CREATE: begin
              mem_we    = 1'b1;
              mem_waddr = '0;
              mem_wdata = push_st;
              cnt_nxt   = CW'(1);
            end
            OP_CLEAR: begin
              cnt_nxt = '0;
            end
            OP_REMOVE_EVEN: begin
              idx_nxt   = '0;
              wr_nxt    = '0;
              state_nxt = S_RE_RD;
            end
            OP_SORT: begin
              if (cnt_r >= CW'(2)) begin
                lim_nxt   = cnt_r;
                state_nxt = S_SRT_LD;
              end
            end
            OP_DUMP: begin
              idx_nxt   = cnt_r;
              state_nxt = S_DMP_RD;
            end
            default: begin
              // unused code: report the top only
            end
          endcase
        end
      end

      S_TOP_RD: begin
        if (cnt_r != '0) begin
          mem_re    = 1'b1;
          mem_raddr = cnt_m1[AW-1:0];
          state_nxt = S_TOP_EM;
        end else if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = st_r;
          out_val_nxt    = '0;
          out_holds_nxt  = 1'b0;
          out_cnt_nxt    = cnt_r;
          out_last_nxt   = 1'b1;
          state_nxt      = S_IDLE;
        end
      end

      S_TOP_EM: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = st_r;
          out_val_nxt    = mem_rdata;
          out_holds_nxt  = 1'b1;
          out_cnt_nxt    = cnt_r;
          out_last_nxt   = 1'b1;
          state_nxt      = S_IDLE;
        end
      end

      S_RE_RD: begin
        if (idx_r == cnt_r) begin
          cnt_nxt   = wr_r;
          state_nxt = S_TOP_RD;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = idx_r[AW-1:0];
          state_nxt = S_RE_CHK;
        end
      end

      S_RE_CHK: begin
        // write index never passes the read index
        if (mem_rdata[0]) begin
          mem_we    = 1'b1;
          mem_waddr = wr_r[AW-1:0];
          mem_wdata = mem_rdata;
          wr_nxt    = wr_r + CW'(1);
        end
        idx_nxt   = idx_p1;
        state_nxt = S_RE_RD;
      end

      S_SRT_LD: begin
        mem_re    = 1'b1;
        mem_raddr = '0;
        idx_nxt   = '0;
        state_nxt = S_SRT_HOLD;
      end

      S_SRT_HOLD: begin
        hold_nxt  = mem_rdata;
        mem_re    = 1'b1;
        mem_raddr = idx_p1[AW-1:0];
        state_nxt = S_SRT_CMP;
      end

      S_SRT_CMP: begin
        // larger value goes down to idx, smaller one travels up
        mem_we    = 1'b1;
        mem_waddr = idx_r[AW-1:0];
        mem_wdata = lt ? mem_rdata : hold_r;
        hold_nxt  = lt ? hold_r : mem_rdata;
        idx_nxt   = idx_p1;
        if (idx_p2 < lim_r) begin
          mem_re    = 1'b1;
          mem_raddr = idx_p2[AW-1:0];
        end else begin
          state_nxt = S_SRT_END;
        end
      end

      S_SRT_END: begin
        mem_we    = 1'b1;
        mem_waddr = lim_m1[AW-1:0];
        mem_wdata = hold_r;
        lim_nxt   = lim_m1;
        state_nxt = (lim_m1 >= CW'(2)) ? S_SRT_LD : S_TOP_RD;
      end

      S_DMP_RD: begin
        if (idx_r == '0) begin
          // empty stack: single marker transaction
          if (out_free) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = ST_OK;
            out_val_nxt    = '0;
            out_holds_nxt  = 1'b0;
            out_cnt_nxt    = cnt_r;
            out_last_nxt   = 1'b1;
            state_nxt      = S_IDLE;
          end
        end else begin
          mem_re    = 1'b1;
          mem_raddr = idx_m1_addr(idx_r);
          state_nxt = S_DMP_EM;
        end
      end

      S_DMP_EM: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_OK;
          out_val_nxt    = mem_rdata;
          out_holds_nxt  = 1'b1;
          out_cnt_nxt    = cnt_r;
          out_last_nxt   = (idx_r == CW'(1));
          idx_nxt        = idx_r - CW'(1);
          state_nxt      = (idx_r == CW'(1)) ? S_IDLE : S_DMP_RD;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    idx_r        <= idx_nxt;
    lim_r        <= lim_nxt;
    wr_r         <= wr_nxt;
    hold_r       <= hold_nxt;
    st_r         <= st_nxt;
    out_status_r <= out_status_nxt;
    out_val_r    <= out_val_nxt;
    out_holds_r  <= out_holds_nxt;
    out_cnt_r    <= out_cnt_nxt;
    out_last_r   <= out_last_nxt;
  end

  // stored value sign-extended from the stored width, cut to 32 bits
  assign out_ext = EXT_W'($signed(out_val_r));

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_element_value = out_ext[VAL_W-1:0];
  assign out_holds_element = out_holds_r;
  assign out_element_count = COUNT_W'(out_cnt_r);
  assign out_last          = out_last_r;

endmodule

// ----- sim/sfs_checker.sv -----
// Stack result checker: predicts every result from accepted operations and compares.
module sfs_checker (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  input  logic                                in_ready,
  input  logic [sfs_pkg::OP_W-1:0]            in_operation,
  input  logic signed [sfs_pkg::VAL_W-1:0]    in_push_value,
  input  logic                                out_valid,
  input  logic                                out_ready,
  input  logic [sfs_pkg::STATUS_W-1:0]        out_status,
  input  logic signed [sfs_pkg::VAL_W-1:0]    out_element_value,
  input  logic                                out_holds_element,
  input  logic [sfs_pkg::COUNT_W-1:0]         out_element_count,
  input  logic                                out_last,
  output int                                  outstanding,
  output int                                  mismatches
);
  timeunit 1ns;
  timeprecision 1ps;
  import sfs_pkg::*;

  localparam int DEPTH = DEPTH_DEF;
  localparam int DW    = DATA_WIDTH_DEF;

  typedef struct packed {
    logic [STATUS_W-1:0]     status;
    logic signed [VAL_W-1:0] value;
    logic                    holds;
    logic [COUNT_W-1:0]      count;
    logic                    last;
  } stack_result_t;

  // index 0 is the bottom, stack_fill-1 the top
  logic signed [DW-1:0] stack_mem [DEPTH];
  int                   stack_fill;
  stack_result_t        expected_results [$];
  stack_result_t        want;

  task automatic report_mismatch(input string what);
    $display("%0t ns  mismatch: %s", $time, what);
    mismatches++;
  endtask

  task automatic queue_result(input logic [STATUS_W-1:0] st, input logic signed [DW-1:0] v,
                              input logic holds, input logic last);
    stack_result_t r;
    r.status = st;
    r.value  = holds ? VAL_W'(v) : '0;
    r.holds  = holds;
    r.count  = COUNT_W'(stack_fill);
    r.last   = last;
    expected_results.push_back(r);
  endtask

  task automatic predict_stack_op(input logic [OP_W-1:0] op,
                                  input logic signed [VAL_W-1:0] val);
    logic [STATUS_W-1:0] st;
    logic signed [DW-1:0] tmp;
    int w;
    st = ST_OK;
    case (op)
      OP_PUSH: begin
        if (stack_fill >= DEPTH) begin
          st = ST_OVERFLOW;
        end else begin
          stack_mem[stack_fill] = DW'(val);
          stack_fill++;
        end
      end
      OP_POP: begin
        if (stack_fill == 0) st = ST_UNDERFLOW;
        else stack_fill--;
      end
      OP_CREATE: begin
        stack_mem[0] = DW'(val);
        stack_fill   = 1;
      end
      OP_CLEAR: stack_fill = 0;
      OP_REMOVE_EVEN: begin
        // odd means lowest bit set, negatives included
        w = 0;
        for (int i = 0; i < stack_fill; i++) begin
          if (stack_mem[i][0]) begin
            stack_mem[w] = stack_mem[i];
            w++;
          end
        end
        stack_fill = w;
      end
      OP_SORT: begin
        // descending by index, smallest ends on top; fewer than two is a no-op
        for (int p = 0; p + 1 < stack_fill; p++) begin
          for (int i = 0; i + 1 < stack_fill - p; i++) begin
            if (stack_mem[i] < stack_mem[i+1]) begin
              tmp            = stack_mem[i];
              stack_mem[i]   = stack_mem[i+1];
              stack_mem[i+1] = tmp;
            end
          end
        end
      end
      OP_DUMP: begin
        if (stack_fill == 0) begin
          queue_result(ST_OK, '0, 1'b0, 1'b1);
        end else begin
          for (int k = 0; k < stack_fill; k++)
            queue_result(ST_OK, stack_mem[stack_fill-1-k], 1'b1, k + 1 == stack_fill);
        end
        return;
      end
      default: ;  // unused code: no change
    endcase
    if (stack_fill > 0) queue_result(st, stack_mem[stack_fill-1], 1'b1, 1'b1);
    else queue_result(st, '0, 1'b0, 1'b1);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      stack_fill = 0;
      expected_results.delete();
      outstanding <= 0;
    end else begin
      if (in_valid && in_ready) predict_stack_op(in_operation, in_push_value);
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("unexpected transaction value %0d count %0d",
                                    out_element_value, out_element_count));
        end else begin
          want = expected_results.pop_front();
          if (out_status !== want.status)
            report_mismatch($sformatf("status %0d, expected %0d", out_status, want.status));
          if (out_element_value !== want.value)
            report_mismatch($sformatf("element_value %0d, expected %0d",
                                      out_element_value, want.value));
          if (out_holds_element !== want.holds)
            report_mismatch($sformatf("holds_element %0b, expected %0b",
                                      out_holds_element, want.holds));
          if (out_element_count !== want.count)
            report_mismatch($sformatf("element_count %0d, expected %0d",
                                      out_element_count, want.count));
          if (out_last !== want.last)
            report_mismatch($sformatf("last %0b, expected %0b", out_last, want.last));
        end
      end
      outstanding <= expected_results.size();
    end
  end

endmodule

// ----- sim/tb_sorting_filtering_stack.sv -----
// Stimulus and verdict for the sorting/filtering stack; checking sits in sfs_checker.
module tb_sorting_filtering_stack;
  timeunit 1ns;
  timeprecision 1ps;
  import sfs_pkg::*;

  // spare opcode, must behave as a no-op returning the top
  localparam logic [OP_W-1:0] OP_UNUSED = 3'd7;
  localparam int RANDOM_ITEMS = 235;

  // every input known from time zero
  logic                    clk           = 1'b0;
  logic                    rst_n         = 1'b0;
  logic                    in_valid      = 1'b0;
  logic                    in_ready;
  logic [OP_W-1:0]         in_operation  = '0;
  logic signed [VAL_W-1:0] in_push_value = '0;
  logic                    out_valid;
  logic                    out_ready     = 1'b0;
  logic [STATUS_W-1:0]     out_status;
  logic signed [VAL_W-1:0] out_element_value;
  logic                    out_holds_element;
  logic [COUNT_W-1:0]      out_element_count;
  logic                    out_last;

  int outstanding;
  int mismatches;

  // sender pacing
  int  burst_left = 0;
  bit  no_idle    = 1'b0;
  int  random_sent;

  // receiver pacing
  int  rx_mode      = 0;
  int  rx_mode_left = 0;
  int  rx_stall     = 0;

  sorting_filtering_stack dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_operation     (in_operation),
    .in_push_value    (in_push_value),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_element_value(out_element_value),
    .out_holds_element(out_holds_element),
    .out_element_count(out_element_count),
    .out_last         (out_last)
  );

  sfs_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_operation     (in_operation),
    .in_push_value    (in_push_value),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_element_value(out_element_value),
    .out_holds_element(out_holds_element),
    .out_element_count(out_element_count),
    .out_last         (out_last),
    .outstanding      (outstanding),
    .mismatches       (mismatches)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Watchdog. The worst honest run, a full sort and held-up dump transactions
  // plus sender gaps for every item, stays well inside 20 ms, after which the
  // run is ended as failed.
  initial begin
    #(20_000_000);
    $display("sorting_filtering_stack test failed");
    $finish;
  end

  // Receiver: ready pattern switches between free running, patchy and
  // long stalls, so backpressure lands on dumps,
  // sorts and single results alike.
  always @(posedge clk) begin
    if (rx_mode_left == 0) begin
      rx_mode      = $urandom_range(0, 2);
      rx_mode_left = $urandom_range(50, 300);
    end
    rx_mode_left--;
    if (rx_stall > 0) begin
      rx_stall--;
      out_ready <= 1'b0;
    end else begin
      case (rx_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= ($urandom_range(0, 3) != 0);
        default: begin
          if ($urandom_range(0, 7) == 0) begin
            rx_stall = $urandom_range(1, 12);
            out_ready <= 1'b0;
          end else begin
            out_ready <= 1'b1;
          end
        end
      endcase
    end
  end

  // One input transaction. Bursts of 1..8 back to back, with random gaps
  // between bursts unless the current stretch runs gap-free. Valid is only
  // dropped for a gap, so no signal gets two updates in one step.
  task automatic send_op(input logic [OP_W-1:0] op, input logic signed [VAL_W-1:0] val);
    int gap;
    if (burst_left == 0) begin
      gap = no_idle ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 8);
    end
    in_valid      <= 1'b1;
    in_operation  <= op;
    in_push_value <= val;
    do @(posedge clk); while (!in_ready);
    burst_left--;
  endtask

  // Mix of full-range, small (duplicates and odd/even both ways) and extremes.
  function automatic logic signed [VAL_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $urandom;
      4, 5, 6:    return $signed($urandom_range(0, 16)) - 8;
      7:          return 32'sh7FFF_FFFF;
      8:          return 32'sh8000_0000;
      default:    return $urandom_range(0, 1) ? 32'sh0 : -32'sd1;
    endcase
  endfunction

  function automatic logic [OP_W-1:0] pick_mixed_op();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return OP_PUSH;
    if (r < 60) return OP_POP;
    if (r < 65) return OP_CREATE;
    if (r < 75) return OP_SORT;
    if (r < 83) return OP_REMOVE_EVEN;
    if (r < 93) return OP_DUMP;
    if (r < 97) return OP_CLEAR;
    return OP_UNUSED;
  endfunction

  // any code, spare one included
  function automatic logic [OP_W-1:0] OP_OP_W_RAND();
    return OP_W'($urandom_range(0, 7));
  endfunction

  // Fill past the top (overflow), then sort and dump the full stack, filter it and dump it again.
  task automatic fill_sequence();
    int n;
    n = $urandom_range(33, 35);
    send_op(OP_CLEAR, $urandom);
    repeat (n) send_op(OP_PUSH, pick_value());
    send_op(OP_SORT, $urandom);
    send_op(OP_DUMP, $urandom);
    send_op(OP_REMOVE_EVEN, $urandom);
    send_op(OP_DUMP, $urandom);
    random_sent += n + 5;
  endtask

  initial begin
    int kind;
    int n;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty-stack corner cases, single-element sort, extremes,
    // negative evens, duplicates and the spare opcode.
    send_op(OP_DUMP, 32'sd0);
    send_op(OP_POP, 32'sd0);
    send_op(OP_SORT, 32'sd0);
    send_op(OP_REMOVE_EVEN, 32'sd0);
    send_op(OP_UNUSED, 32'sd0);
    send_op(OP_CREATE, -32'sd1);
    send_op(OP_SORT, 32'sd0);
    send_op(OP_PUSH, 32'sd0);
    send_op(OP_PUSH, -32'sd2);
    send_op(OP_PUSH, 32'sh7FFF_FFFF);
    send_op(OP_PUSH, 32'sh8000_0000);
    send_op(OP_PUSH, -32'sd3);
    send_op(OP_PUSH, 32'sd5);
    send_op(OP_UNUSED, 32'sh5A5A_5A5A);
    send_op(OP_DUMP, 32'sd0);
    send_op(OP_SORT, 32'sd0);
    send_op(OP_DUMP, 32'sd0);
    send_op(OP_REMOVE_EVEN, 32'sd0);
    send_op(OP_DUMP, 32'sd0);
    send_op(OP_POP, 32'sd0);
    send_op(OP_CLEAR, 32'sd0);
    send_op(OP_DUMP, 32'sd0);
    send_op(OP_CREATE, 32'sh8000_0000);
    send_op(OP_PUSH, 32'sh8000_0000);
    send_op(OP_SORT, 32'sd0);

    // Random: mostly structured sequences with random content, a fill run
    // first so overflow is always reached, then drains and pure noise.
    random_sent = 0;
    fill_sequence();
    while (random_sent < RANDOM_ITEMS) begin
      no_idle = ($urandom_range(0, 3) == 0);
      kind    = $urandom_range(0, 8);
      if (kind < 2) begin
        fill_sequence();
      end else if (kind < 6) begin
        n = $urandom_range(3, 10);
        repeat (n) send_op(pick_mixed_op(), pick_value());
        random_sent += n;
      end else if (kind < 8) begin
        // drain, often past empty for underflow
        n = $urandom_range(1, 36);
        repeat (n) send_op(OP_POP, $urandom);
        send_op(OP_DUMP, $urandom);
        random_sent += n + 1;
      end else begin
        n = $urandom_range(1, 6);
        repeat (n) send_op(OP_OP_W_RAND(), $urandom);
        random_sent += n;
      end
    end
    in_valid <= 1'b0;

    // drain the result channel, then wait for stragglers
    do @(posedge clk); while (outstanding != 0);
    repeat (10) @(posedge clk);

    if (mismatches == 0) $display("sorting_filtering_stack test passed");
    else $display("sorting_filtering_stack test failed");
    $finish;
  end

endmodule
